/* design/gftu_pkg.sv */
package gftu_pkg;
    typedef enum logic [2:0] {
        F_TICK = 3'd0, F_READ = 3'd1, F_WRITE = 3'd2, F_HB_START = 3'd3,
        F_HB_END = 3'd4, F_VB_START = 3'd5, F_VB_END = 3'd6, F_NONE = 3'd7
    } t_func;

    localparam logic [1:0] REG_COUNT  = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_TARGET = 2'd2;
    localparam logic [1:0] REG_HOLD   = 2'd3;

    localparam logic [1:0] CLK_HBLANK = 2'd3;

    // control state seen by each timer slice (sel is set per slice)
    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  reg_sel;
        logic        sel;
        logic [31:0] data;
        logic [8:0]  phase;
        logic        in_hblank;
        logic        in_vblank;
    } t_ctl;
endpackage

/* design/gftu_timer.sv */
module gftu_timer
    import gftu_pkg::*;
#(
    parameter int HBLANK_STEP = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_ctl        i_ctl,
    output logic [15:0] o_count,
    output logic [11:0] o_mode,
    output logic [15:0] o_target,
    output logic        o_irq
);
    logic [16:0] r_count, n_count;
    logic [11:0] r_mode, n_mode;
    logic [15:0] r_target, n_target;
    logic        r_dis, n_dis;

    logic [1:0] clk_src;
    logic [1:0] gm;
    logic       may;
    logic       step_hit;
    logic [8:0] msk;

    always_comb begin
        clk_src = r_mode[1:0];
        gm = r_mode[5:4];
        if (!r_mode[7])
            may = 1'b0;
        else if (!r_mode[2])
            may = 1'b1;
        else if (!r_mode[3])
            may = (clk_src != CLK_HBLANK) && (!i_ctl.in_hblank || gm != 2'd0);
        else
            may = !i_ctl.in_vblank || gm != 2'd0;
        case (clk_src)
            2'd0:    msk = 9'd1;
            2'd1:    msk = 9'd31;
            default: msk = 9'd511;
        endcase
        step_hit = (i_ctl.phase & msk) == 9'd0;
    end

    always_comb begin
        logic        run;
        logic [16:0] c;
        logic [11:0] m;
        logic        d;
        logic        irq;
        run = 1'b0;
        c = r_count;
        m = r_mode;
        d = r_dis;
        irq = 1'b0;
        n_target = r_target;
        case (t_func'(i_ctl.func))
            F_TICK: begin
                if (clk_src != CLK_HBLANK && may) begin
                    run = 1'b1;
                    if (step_hit)
                        c = c + 17'd1;
                end
            end
            F_HB_START: begin
                if (clk_src == CLK_HBLANK && may) begin
                    run = 1'b1;
                    c = c + 17'(HBLANK_STEP);
                end
            end
            F_WRITE: begin
                if (i_ctl.sel) begin
                    case (i_ctl.reg_sel)
                        REG_COUNT: begin
                            c = {1'b0, i_ctl.data[15:0]};
                            d = i_ctl.data[15:0] >= r_target;
                        end
                        REG_MODE: begin
                            m = {r_mode[11:10] & ~i_ctl.data[11:10], i_ctl.data[9:0]};
                        end
                        REG_TARGET: begin
                            n_target = i_ctl.data[15:0];
                            d = i_ctl.data[15:0] <= r_count;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        if (run) begin
            if (c[16]) begin
                if (m[9] && !m[11]) begin
                    m[11] = 1'b1;
                    irq = 1'b1;
                end
                c[16] = 1'b0;
                d = 1'b0;
            end
            if (!d && c >= {1'b0, r_target}) begin
                if (m[8] && !m[10]) begin
                    m[10] = 1'b1;
                    irq = 1'b1;
                end
                if (m[6])
                    c = c - {1'b0, r_target};
                else
                    d = 1'b1;
            end
        end
        // gate edges clear the count
        if (m[2]) begin
            case (t_func'(i_ctl.func))
                F_HB_START: if (!m[3] && m[4]) begin c = '0; d = 1'b0; end
                F_HB_END:   if (!m[3] && m[5]) begin c = '0; d = 1'b0; end
                F_VB_START: if (m[3] && m[4]) begin c = '0; d = 1'b0; end
                F_VB_END:   if (m[3] && m[5]) begin c = '0; d = 1'b0; end
                default: ;
            endcase
        end
        n_count = c;
        n_mode = m;
        n_dis = d;
        o_irq = irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_mode   <= '0;
            r_target <= 16'hffff;
            r_dis    <= 1'b0;
        end else if (i_en) begin
            r_count  <= n_count;
            r_mode   <= n_mode;
            r_target <= n_target;
            r_dis    <= n_dis;
        end
    end

    assign o_count  = r_count[15:0];
    assign o_mode   = r_mode;
    assign o_target = r_target;
endmodule

/* design/gated_four_timer_unit.sv */
// Four 16-bit timers driven by one transaction per cycle (bus tick, register
// read or write, hblank/vblank start or end). Each accepted transaction
// updates all timer state in the same cycle and its result (read data and
// per-timer interrupt pulses) is captured in an output register;
// the block takes a new transaction every cycle, stalling only while that
// output register is full and not taken. Clock dividers /2, /32, /512 share
// one 9-bit phase counter. Timers beyond TIMER_COUNT read as zero.
module gated_four_timer_unit
    import gftu_pkg::*;
#(
    parameter int TIMER_COUNT = 4,
    parameter int HBLANK_STEP = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [3:0]  i_reg_address,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_read_data,
    output logic [3:0]  o_irq_raised
);
    logic        acc;
    logic [8:0]  r_phase;
    logic        r_hblank, r_vblank;
    logic [31:0] r_hold [2];
    logic [15:0] cnt [4];
    logic [11:0] mde [4];
    logic [15:0] tgt [4];
    logic [3:0]  irq;
    logic [1:0]  tsel;
    logic [1:0]  rsel;
    logic [15:0] rd;
    t_ctl        ctl;

    // output register frees up whenever the consumer takes it
    assign o_ready = !o_valid || i_ready;
    assign acc = i_valid && o_ready;
    assign tsel = i_reg_address[3:2];
    assign rsel = i_reg_address[1:0];

    always_comb begin
        ctl.func = i_func;
        ctl.reg_sel = rsel;
        ctl.sel = 1'b0;
        ctl.data = i_write_data;
        ctl.phase = (t_func'(i_func) == F_TICK) ? r_phase + 9'd1 : r_phase;
        ctl.in_hblank = r_hblank;
        ctl.in_vblank = r_vblank;
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_tmr
            if (g < TIMER_COUNT) begin : g_on
                t_ctl c;
                always_comb begin
                    c = ctl;
                    c.sel = (tsel == 2'(g));
                end
                gftu_timer #(.HBLANK_STEP(HBLANK_STEP)) u_tmr (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(acc), .i_ctl(c),
                    .o_count(cnt[g]), .o_mode(mde[g]), .o_target(tgt[g]),
                    .o_irq(irq[g])
                );
            end else begin : g_off
                assign cnt[g] = '0;
                assign mde[g] = '0;
                assign tgt[g] = '0;
                assign irq[g] = 1'b0;
            end
        end
    endgenerate

    // register read mux
    always_comb begin
        rd = '0;
        if (t_func'(i_func) == F_READ && 32'(tsel) < 32'(TIMER_COUNT)) begin
            case (rsel)
                REG_COUNT:  rd = cnt[tsel];
                REG_MODE:   rd = {4'd0, mde[tsel]};
                REG_TARGET: rd = tgt[tsel];
                default:    rd = tsel[1] ? 16'd0 : r_hold[tsel[0]][15:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_hblank <= 1'b0;
            r_vblank <= 1'b0;
            r_hold[0] <= '0;
            r_hold[1] <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (acc) begin
                r_phase <= ctl.phase;
                case (t_func'(i_func))
                    F_HB_START: r_hblank <= 1'b1;
                    F_HB_END:   r_hblank <= 1'b0;
                    F_VB_START: r_vblank <= 1'b1;
                    F_VB_END:   r_vblank <= 1'b0;
                    F_WRITE: begin
                        if (rsel == REG_HOLD && !tsel[1]
                            && 32'(tsel) < 32'(TIMER_COUNT))
                            r_hold[tsel[0]] <= i_write_data;
                    end
                    default: ;
                endcase
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            o_read_data  <= rd;
            o_irq_raised <= irq;
        end
    end
endmodule

/* design/gftu_checker.sv */
module gftu_props
    import gftu_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [2:0]  i_func,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_read_data,
    input logic [3:0]  o_irq_raised
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data)) else $error("out hold");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("ready while empty");
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_func != F_READ |=> o_read_data == 16'd0) else $error("rd");
    a_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_func != F_TICK && i_func != F_HB_START
        |=> o_irq_raised == 4'd0)
        else $error("irq");
endmodule

bind gated_four_timer_unit gftu_props u_chk (.*);
